// ===== rtl/core/etmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etmr_pkg
// Shared types, codes and constants for the event timer table.
// ----------------------------------------------------------------------------
package etmr_pkg;

	localparam int TimerSlotsDefault = 32;
	localparam int UsPerMs = 1000;

	// action codes
	localparam logic [2:0] ACT_UPDATE   = 3'd0;
	localparam logic [2:0] ACT_SET_ONE  = 3'd1;
	localparam logic [2:0] ACT_SET_PER  = 3'd2;
	localparam logic [2:0] ACT_STOP     = 3'd3;
	localparam logic [2:0] ACT_STOP_ALL = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// result kinds
	localparam logic KIND_FIRED = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] event_id;
		logic [22:0] period_ms;
		logic [31:0] tick_now;
	} etmr_in_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] fired_id;
		logic [1:0]  status;
		logic [31:0] system_us;
		logic [5:0]  active_count;
		logic        last;
	} etmr_out_t;

endpackage

// ===== rtl/core/etmr_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etmr_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface etmr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/etmr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etmr_div
// Restoring 32-bit remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module etmr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] rem
);
	import etmr_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			// pulse done on the last iteration
			done_q <= busy_q && !start && (cnt_q == 6'd1);
			if (start) begin
				rem_q  <= '0;
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				cnt_q  <= 6'd32;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// keep the trial when the subtraction underflows
				rem_q <= diff[32] ? trial[31:0] : diff[31:0];
				dvd_q <= {dvd_q[30:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// ===== rtl/core/event_timer_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_timer_table_unit
// Table of one-shot and periodic microsecond timers keyed by event id.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload     transfer
//  in_ch    in   etmr_in_t   one action
//  out_ch   out  etmr_out_t  one result (fired notices, then closing status)
//  cfg      in   tick_shift  write on cfg_we, no wait
//
// An action scans each valid table entry on each scan pass in a memory read
// step and a modify/write step, runs the bit-serial remainder unit once per
// periodic expiry with a nonzero period, and emits each fired notice in a
// read step and a write step.
// Reset clears all valid bits at once; no clearing pass is needed.
// Output stalls hold the emit sequencer; the output register lets the next
// action be taken while the closing result still waits.
// ----------------------------------------------------------------------------
module event_timer_table_unit #(
	parameter int TIMER_SLOTS = etmr_pkg::TimerSlotsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_wdata,
	etmr_stream_if.sink         in_ch,
	etmr_stream_if.source       out_ch
);
	import etmr_pkg::*;

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_UPD      = 4'd1;
	localparam logic [3:0] S_SCAN_RD  = 4'd2;
	localparam logic [3:0] S_SCAN_EX  = 4'd3;
	localparam logic [3:0] S_DIV      = 4'd4;
	localparam logic [3:0] S_FIND_RD  = 4'd5;
	localparam logic [3:0] S_FIND_EX  = 4'd6;
	localparam logic [3:0] S_FIND_END = 4'd7;
	localparam logic [3:0] S_CLR      = 4'd8;
	localparam logic [3:0] S_EMIT_RD  = 4'd9;
	localparam logic [3:0] S_EMIT_WR  = 4'd10;
	localparam logic [3:0] S_CLOSE    = 4'd11;

	typedef struct packed {
		logic [31:0] ev;
		logic [31:0] tl;
		logic [31:0] per;
	} ent_t;

	// entry memory and fired-id buffer
	ent_t        ent_mem [TIMER_SLOTS];
	logic [31:0] fbuf_mem [TIMER_SLOTS];
	ent_t        rd_q;
	logic [31:0] fbuf_rd_q;

	logic                   mem_re;
	logic                   mem_we;
	logic [IW-1:0]          mem_waddr;
	ent_t                   mem_wdata;
	logic                   fbuf_we;
	logic                   fbuf_re;

	// control state
	logic [3:0]             state_q;
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [TIMER_SLOTS-1:0] perflag_q;
	logic [CW-1:0]          count_q;
	logic [31:0]            time_q;
	logic [31:0]            last_tick_q;
	logic [3:0]             tick_shift_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          fcnt_q;
	logic [CW-1:0]          emit_q;
	logic [IW-1:0]          free_q;
	logic                   free_ok_q;
	logic [1:0]             status_q;
	logic                   out_valid_q;
	etmr_out_t              out_q;

	// action operands
	logic [2:0]             act_q;
	logic [31:0]            id_q;
	logic [31:0]            per_us_q;
	logic [31:0]            us_q;

	logic                   slot_free;
	logic                   out_load;
	logic [IW-1:0]          idx;
	logic                   fire;
	logic                   div_start;
	logic                   div_done;
	logic [31:0]            div_rem;
	logic                   is_set;
	ent_t                   new_ent;

	assign idx       = idx_q[IW-1:0];
	assign slot_free = !out_valid_q || out_ch.ready;
	assign out_load  = ((state_q == S_EMIT_WR) || (state_q == S_CLOSE)) && slot_free;
	assign fire      = !(us_q < rd_q.tl);
	assign is_set    = (act_q == ACT_SET_ONE) || (act_q == ACT_SET_PER);
	assign new_ent   = '{ev: id_q, tl: per_us_q, per: per_us_q};

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	etmr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (us_q),
		.divisor  (rd_q.per),
		.done     (div_done),
		.rem      (div_rem)
	);

	// memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx;
		mem_wdata = rd_q;
		fbuf_we   = 1'b0;
		fbuf_re   = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			S_SCAN_RD, S_FIND_RD: begin
				mem_re = (idx_q != SLOTS_C) && valid_q[idx];
			end
			S_SCAN_EX: begin
				if (!fire) begin
					mem_we       = 1'b1;
					mem_wdata.tl = rd_q.tl - us_q;
				end else begin
					fbuf_we = 1'b1;
					if (perflag_q[idx]) begin
						if (rd_q.per == 32'd0) begin
							mem_we       = 1'b1;
							mem_wdata.tl = 32'd0;
						end else begin
							div_start = 1'b1;
						end
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					mem_we       = 1'b1;
					mem_wdata.tl = rd_q.tl + rd_q.per - div_rem;
				end
			end
			S_FIND_EX: begin
				if (rd_q.ev == id_q && is_set) begin
					mem_we    = 1'b1;
					mem_wdata = new_ent;
				end
			end
			S_FIND_END: begin
				if (is_set && free_ok_q) begin
					mem_we    = 1'b1;
					mem_waddr = free_q;
					mem_wdata = new_ent;
				end
			end
			S_EMIT_RD: begin
				fbuf_re = (emit_q != fcnt_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			ent_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= ent_mem[idx];
	end

	always_ff @(posedge clk) begin
		if (fbuf_we)
			fbuf_mem[fcnt_q[IW-1:0]] <= rd_q.ev;
		if (fbuf_re)
			fbuf_rd_q <= fbuf_mem[emit_q[IW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			perflag_q    <= '0;
			count_q      <= '0;
			time_q       <= '0;
			last_tick_q  <= '0;
			tick_shift_q <= 4'd4;
			idx_q        <= '0;
			fcnt_q       <= '0;
			emit_q       <= '0;
			free_q       <= '0;
			free_ok_q    <= 1'b0;
			status_q     <= ST_OK;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			act_q        <= ACT_UPDATE;
			id_q         <= '0;
			per_us_q     <= '0;
			us_q         <= '0;
		end else begin
			if (cfg_we)
				tick_shift_q <= cfg_wdata;

			// hold the result until the sink takes it, then load the next one
			out_valid_q <= out_load || (out_valid_q && !out_ch.ready);

			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						act_q     <= in_ch.data.action;
						id_q      <= in_ch.data.event_id;
						per_us_q  <= 32'(in_ch.data.period_ms * 32'(UsPerMs));
						us_q      <= (in_ch.data.tick_now - last_tick_q) >> tick_shift_q;
						idx_q     <= '0;
						fcnt_q    <= '0;
						emit_q    <= '0;
						free_ok_q <= 1'b0;
						status_q  <= ST_OK;
						unique case (in_ch.data.action)
							ACT_UPDATE, ACT_SET_ONE: state_q <= S_UPD;
							ACT_SET_PER, ACT_STOP:   state_q <= S_FIND_RD;
							ACT_STOP_ALL:            state_q <= S_CLR;
							default:                 state_q <= S_CLOSE;
						endcase
					end
				end
				S_UPD: begin
					// advance system time and the tick reference
					if (us_q != 32'd0) begin
						time_q      <= time_q + us_q;
						last_tick_q <= last_tick_q + 32'(us_q << tick_shift_q);
					end
					state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					if (idx_q == SLOTS_C) begin
						idx_q   <= '0;
						state_q <= (act_q == ACT_SET_ONE) ? S_FIND_RD : S_EMIT_RD;
					end else if (!valid_q[idx]) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_SCAN_EX;
					end
				end
				S_SCAN_EX: begin
					if (fire) begin
						fcnt_q <= fcnt_q + 1'b1;
						if (!perflag_q[idx]) begin
							valid_q[idx] <= 1'b0;
							count_q      <= count_q - 1'b1;
						end
					end
					if (div_start) begin
						state_q <= S_DIV;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_DIV: begin
					if (div_done) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_FIND_RD: begin
					if (idx_q == SLOTS_C) begin
						state_q <= S_FIND_END;
					end else if (!valid_q[idx]) begin
						// remember the lowest free slot
						if (!free_ok_q) begin
							free_q    <= idx;
							free_ok_q <= 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_FIND_EX;
					end
				end
				S_FIND_EX: begin
					if (rd_q.ev == id_q) begin
						if (is_set) begin
							perflag_q[idx] <= (act_q == ACT_SET_PER);
						end else begin
							valid_q[idx] <= 1'b0;
							count_q      <= count_q - 1'b1;
						end
						state_q <= S_EMIT_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_FIND_RD;
					end
				end
				S_FIND_END: begin
					if (is_set) begin
						if (free_ok_q) begin
							valid_q[free_q]   <= 1'b1;
							perflag_q[free_q] <= (act_q == ACT_SET_PER);
							count_q           <= count_q + 1'b1;
						end else begin
							status_q <= ST_FULL;
						end
					end else begin
						status_q <= ST_NOT_FOUND;
					end
					state_q <= S_EMIT_RD;
				end
				S_CLR: begin
					valid_q <= '0;
					count_q <= '0;
					state_q <= S_CLOSE;
				end
				S_EMIT_RD: begin
					state_q <= (emit_q == fcnt_q) ? S_CLOSE : S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (slot_free) begin
						out_q.kind         <= KIND_FIRED;
						out_q.fired_id     <= fbuf_rd_q;
						out_q.status       <= ST_OK;
						out_q.system_us    <= time_q;
						out_q.active_count <= 6'(count_q);
						out_q.last         <= 1'b0;
						emit_q             <= emit_q + 1'b1;
						state_q            <= S_EMIT_RD;
					end
				end
				S_CLOSE: begin
					if (slot_free) begin
						out_q.kind         <= KIND_CLOSE;
						out_q.fired_id     <= 32'd0;
						out_q.status       <= status_q;
						out_q.system_us    <= time_q;
						out_q.active_count <= 6'(count_q);
						out_q.last         <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the running count tracks the valid bits
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("timer count out of step with valid bits");

	// remainder results arrive only while waiting for them
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("remainder done outside wait state");

	// fired entries never exceed the table size
	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= SLOTS_C && emit_q <= fcnt_q)
		else $error("fired buffer pointers out of range");

	// a result is loaded only into a free output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOSE && out_valid_q && !out_ch.ready) |=> state_q == S_CLOSE)
		else $error("closing result overran a stalled output");

endmodule
